// ===== rtl/pcv_pkg.sv =====
package pcv_pkg;

    // string length and count saturation
    localparam logic [3:0] CODE_LEN  = 4'd13;
    localparam logic [3:0] COUNT_SAT = 4'd14;
    localparam logic [3:0] SUM_LEN   = 4'd12;

    // character positions of the captured fields
    localparam logic [3:0] POS_SEX       = 4'd0;
    localparam logic [3:0] POS_YEAR_HI   = 4'd1;
    localparam logic [3:0] POS_YEAR_LO   = 4'd2;
    localparam logic [3:0] POS_MONTH_HI  = 4'd3;
    localparam logic [3:0] POS_MONTH_LO  = 4'd4;
    localparam logic [3:0] POS_DAY_HI    = 4'd5;
    localparam logic [3:0] POS_DAY_LO    = 4'd6;
    localparam logic [3:0] POS_COUNTY_HI = 4'd7;
    localparam logic [3:0] POS_COUNTY_LO = 4'd8;
    localparam logic [3:0] POS_CHECK     = 4'd12;

    // limits of the field checks
    localparam logic [11:0] YEAR_MIN   = 12'd1800;
    localparam logic [11:0] YEAR_MAX   = 12'd2099;
    localparam logic [11:0] BASE_1800  = 12'd1800;
    localparam logic [11:0] BASE_1900  = 12'd1900;
    localparam logic [11:0] BASE_2000  = 12'd2000;
    localparam logic [6:0]  COUNTY_MAX = 7'd52;
    localparam logic [6:0]  MONTH_MAX  = 7'd12;
    localparam logic [6:0]  MONTH_FEB  = 7'd2;
    localparam logic [4:0]  DAYS_LEAP  = 5'd29;

    // result codes, first failing check wins
    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_LENGTH   = 4'd1,
        ERR_NONDIGIT = 4'd2,
        ERR_SEX      = 4'd3,
        ERR_YEAR     = 4'd4,
        ERR_MONTH    = 4'd5,
        ERR_DAY      = 4'd6,
        ERR_COUNTY   = 4'd7,
        ERR_CHECKSUM = 4'd8
    } t_err;

    // state of one finished string, handed to the judge stage
    typedef struct packed {
        logic [3:0] count;
        logic       nondigit;
        logic [9:0] sum;
        logic [3:0] sex;
        logic [6:0] year;
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] county;
        logic [3:0] check;
    } t_snap;

    // checksum weight for each position, zero past the weighted part
    function automatic logic [3:0] digit_weight(input logic [3:0] pos);
        logic [3:0] w;
        case (pos)
            4'd0:    w = 4'd2;
            4'd1:    w = 4'd7;
            4'd2:    w = 4'd9;
            4'd3:    w = 4'd1;
            4'd4:    w = 4'd4;
            4'd5:    w = 4'd6;
            4'd6:    w = 4'd3;
            4'd7:    w = 4'd5;
            4'd8:    w = 4'd8;
            4'd9:    w = 4'd2;
            4'd10:   w = 4'd7;
            4'd11:   w = 4'd9;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // days in a common year, zero for a month out of range
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/pcv_accum.sv =====
module pcv_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_character,
    input  logic            i_last_char,
    input  logic            i_snap_free,
    output logic            o_snap_load,
    output pcv_pkg::t_snap  o_snap
);

    logic           r_in_valid;
    logic [7:0]     r_in_char;
    logic           r_in_last;
    pcv_pkg::t_snap r_st;
    pcv_pkg::t_snap n_st;

    logic       is_digit;
    logic [3:0] dig;
    logic [7:0] prod;
    logic [6:0] dig_x10;
    logic       s1_adv;

    // input beat leaves the register unless a last char meets a full snapshot whose result cannot move on
    assign s1_adv      = r_in_valid && (!r_in_last || i_snap_free);
    assign o_ready     = !r_in_valid || s1_adv;
    assign o_snap_load = s1_adv && r_in_last;
    assign o_snap      = n_st;

    // digit decode and per-position update
    always_comb begin
        is_digit = (r_in_char >= 8'h30) && (r_in_char <= 8'h39);
        dig      = is_digit ? r_in_char[3:0] : 4'd0;
        prod     = {4'd0, dig} * {4'd0, pcv_pkg::digit_weight(r_st.count)};
        dig_x10  = {dig, 3'b000} + {2'b00, dig, 1'b0};
        n_st     = r_st;
        if (!is_digit) begin
            n_st.nondigit = 1'b1;
        end
        if (r_st.count < pcv_pkg::CODE_LEN) begin
            if (r_st.count < pcv_pkg::SUM_LEN) begin
                n_st.sum = r_st.sum + {2'b00, prod};
            end
            case (r_st.count)
                pcv_pkg::POS_SEX:       n_st.sex    = dig;
                pcv_pkg::POS_YEAR_HI:   n_st.year   = dig_x10;
                pcv_pkg::POS_YEAR_LO:   n_st.year   = r_st.year + {3'd0, dig};
                pcv_pkg::POS_MONTH_HI:  n_st.month  = dig_x10;
                pcv_pkg::POS_MONTH_LO:  n_st.month  = r_st.month + {3'd0, dig};
                pcv_pkg::POS_DAY_HI:    n_st.day    = dig_x10;
                pcv_pkg::POS_DAY_LO:    n_st.day    = r_st.day + {3'd0, dig};
                pcv_pkg::POS_COUNTY_HI: n_st.county = dig_x10;
                pcv_pkg::POS_COUNTY_LO: n_st.county = r_st.county + {3'd0, dig};
                pcv_pkg::POS_CHECK:     n_st.check  = dig;
                default: ;
            endcase
        end
        if (r_st.count < pcv_pkg::COUNT_SAT) begin
            n_st.count = r_st.count + 4'd1;
        end
    end

    // input register and running state, cleared after each last char
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (o_ready && i_valid) begin
                r_in_char <= i_character;
                r_in_last <= i_last_char;
            end
            if (s1_adv) begin
                r_st <= r_in_last ? '0 : n_st;
            end
        end
    end

endmodule

// ===== rtl/pcv_judge.sv =====
module pcv_judge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_snap_load,
    input  pcv_pkg::t_snap  i_snap,
    output logic            o_snap_free,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_code_valid,
    output logic [3:0]      o_error_kind
);

    logic           r_snap_valid;
    pcv_pkg::t_snap r_snap;
    logic           r_res_valid;
    pcv_pkg::t_err  r_err;
    pcv_pkg::t_err  n_err;

    logic        res_free;
    logic [11:0] base;
    logic [11:0] full_year;
    logic        leap;
    logic [4:0]  dim;
    logic [16:0] sum_x93;
    logic [6:0]  quot;
    logic [9:0]  quot_x11;
    logic [9:0]  rem_wide;
    logic [3:0]  rem;
    logic [3:0]  chk;

    assign res_free     = !r_res_valid || i_ready;
    assign o_snap_free  = !r_snap_valid || res_free;
    assign o_valid      = r_res_valid;
    assign o_code_valid = (r_err == pcv_pkg::ERR_OK);
    assign o_error_kind = r_err;

    // century from the sex digit
    always_comb begin
        if (r_snap.sex == 4'd3 || r_snap.sex == 4'd4) begin
            base = pcv_pkg::BASE_1800;
        end else if (r_snap.sex >= 4'd5 && r_snap.sex <= 4'd9) begin
            base = pcv_pkg::BASE_2000;
        end else begin
            base = pcv_pkg::BASE_1900;
        end
        full_year = base + {5'd0, r_snap.year};
    end

    // leap year: the base is a multiple of 100 and the year in century stays below 100
    always_comb begin
        leap = ((r_snap.year[1:0] == 2'b00) && (r_snap.year != 7'd0))
            || ((r_snap.year == 7'd0) && (base == pcv_pkg::BASE_2000));
        dim  = pcv_pkg::month_days(r_snap.month[3:0]);
        if (r_snap.month == pcv_pkg::MONTH_FEB && leap) begin
            dim = pcv_pkg::DAYS_LEAP;
        end
    end

    // sum mod 11: reciprocal estimate is exact or one short, one correction
    always_comb begin
        sum_x93  = {7'd0, r_snap.sum} * 17'd93;
        quot     = sum_x93[16:10];
        quot_x11 = {quot, 3'b000} + {2'b00, quot, 1'b0} + {3'b000, quot};
        rem_wide = r_snap.sum - quot_x11;
        if (rem_wide >= 10'd11) begin
            rem_wide = rem_wide - 10'd11;
        end
        rem = rem_wide[3:0];
        chk = (rem == 4'd10) ? 4'd1 : rem;
    end

    // first failing check
    always_comb begin
        if (r_snap.count != pcv_pkg::CODE_LEN) begin
            n_err = pcv_pkg::ERR_LENGTH;
        end else if (r_snap.nondigit) begin
            n_err = pcv_pkg::ERR_NONDIGIT;
        end else if (r_snap.sex == 4'd0 || r_snap.sex > 4'd9) begin
            n_err = pcv_pkg::ERR_SEX;
        end else if (full_year < pcv_pkg::YEAR_MIN || full_year > pcv_pkg::YEAR_MAX) begin
            n_err = pcv_pkg::ERR_YEAR;
        end else if (r_snap.month == 7'd0 || r_snap.month > pcv_pkg::MONTH_MAX) begin
            n_err = pcv_pkg::ERR_MONTH;
        end else if (r_snap.day == 7'd0 || r_snap.day > {2'b00, dim}) begin
            n_err = pcv_pkg::ERR_DAY;
        end else if (r_snap.county == 7'd0 || r_snap.county > pcv_pkg::COUNTY_MAX) begin
            n_err = pcv_pkg::ERR_COUNTY;
        end else if (r_snap.check != chk) begin
            n_err = pcv_pkg::ERR_CHECKSUM;
        end else begin
            n_err = pcv_pkg::ERR_OK;
        end
    end

    // snapshot and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            if (o_snap_free) begin
                r_snap_valid <= i_snap_load;
            end
            if (i_snap_load && o_snap_free) begin
                r_snap <= i_snap;
            end
            if (res_free) begin
                r_res_valid <= r_snap_valid;
            end
            if (r_snap_valid && res_free) begin
                r_err <= n_err;
            end
        end
    end

endmodule

// ===== rtl/personal_code_validator.sv =====
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_character[7:0], i_last_char
// result    out        o_valid / i_ready    o_code_valid, o_error_kind[3:0]
//
// one character beat per cycle while o_ready is high; a string's last char reaches the
// result through the input register, snapshot register and result register
// reset clears all valids and the running state, ready for a new string
// characters keep flowing while a result waits; a last char holds in the
// input register only while both the snapshot and the result are occupied
module personal_code_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_character,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_code_valid,
    output logic [3:0] o_error_kind
);

    logic           snap_free;
    logic           snap_load;
    pcv_pkg::t_snap snap;

    // running count, flags, sum and captured fields
    pcv_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .i_snap_free (snap_free),
        .o_snap_load (snap_load),
        .o_snap      (snap)
    );

    // field checks and result register
    pcv_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_load  (snap_load),
        .i_snap       (snap),
        .o_snap_free  (snap_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_valid (o_code_valid),
        .o_error_kind (o_error_kind)
    );

endmodule

// ===== rtl/pcv_checker.sv =====
module pcv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_character,
    input logic       i_last_char,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_code_valid,
    input logic [3:0] o_error_kind
);

    // result code stays within the defined checks
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_kind <= pcv_pkg::ERR_CHECKSUM))
        else $error("error kind out of range");

    // pass flag agrees with the result code
    a_pass_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_valid == (o_error_kind == pcv_pkg::ERR_OK)))
        else $error("code valid disagrees with error kind");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_error_kind)
            && $stable(o_code_valid)))
        else $error("result beat changed while stalled");

    // no result right out of reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind personal_code_validator pcv_checker u_pcv_checker (.*);

// ===== bench/tb_personal_code_validator.sv =====
module tb_personal_code_validator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam int CHK_WEIGHT [12] = '{2, 7, 9, 1, 4, 6, 3, 5, 8, 2, 7, 9};

    typedef logic [7:0] t_chars [$];

    typedef struct {
        logic          ok;
        pcv_pkg::t_err kind;
    } t_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_character;
    logic       i_last_char;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_code_valid;
    logic [3:0] o_error_kind;

    // running state of the code being assembled
    logic [3:0] run_count    = '0;
    logic       run_nondigit = 1'b0;
    logic [9:0] run_sum      = '0;
    logic [3:0] run_sex      = '0;
    logic [6:0] run_year     = '0;
    logic [6:0] run_month    = '0;
    logic [6:0] run_day      = '0;
    logic [6:0] run_county   = '0;
    logic [3:0] run_check    = '0;

    t_verdict verdict_q [$];
    t_verdict want_v;
    int       fail_count = 0;

    // sender pacing
    int burst_left = 0;
    int gap_max    = 4;
    int sent_chars = 0;

    // receiver stall pattern
    int         rx_left  = 0;
    int         rx_style = 0;
    logic [1:0] rx_phase = '0;

    personal_code_validator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_character  (i_character),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_valid (o_code_valid),
        .o_error_kind (o_error_kind)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // century picked by the sex digit
    function automatic int century_of(input int sex);
        if (sex == 3 || sex == 4) return 1800;
        if (sex >= 5 && sex <= 9) return 2000;
        return 1900;
    endfunction

    // days in a month, leap years included, zero for a bad month
    function automatic int month_length(input int mon, input int yr);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mon)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // first failing check of the finished code
    function automatic pcv_pkg::t_err judge_code();
        int yr;
        int rem;
        if (run_count != 4'd13) return pcv_pkg::ERR_LENGTH;
        if (run_nondigit) return pcv_pkg::ERR_NONDIGIT;
        if (run_sex < 1 || run_sex > 9) return pcv_pkg::ERR_SEX;
        yr = century_of(run_sex) + run_year;
        if (yr < 1800 || yr > 2099) return pcv_pkg::ERR_YEAR;
        if (run_month < 1 || run_month > 12) return pcv_pkg::ERR_MONTH;
        if (run_day < 1 || run_day > month_length(run_month, yr)) return pcv_pkg::ERR_DAY;
        if (run_county < 1 || run_county > 52) return pcv_pkg::ERR_COUNTY;
        rem = run_sum % 11;
        if (rem == 10) rem = 1;
        if (run_check != rem) return pcv_pkg::ERR_CHECKSUM;
        return pcv_pkg::ERR_OK;
    endfunction

    // fold one accepted character into the running state
    function automatic void absorb_char(input logic [7:0] ch, input logic last);
        logic [3:0] dig;
        logic [3:0] pos;
        t_verdict   v;
        pos = run_count;
        dig = 4'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE) dig = 4'(ch - CH_ZERO);
        else run_nondigit = 1'b1;
        if (pos < 4'd13) begin
            if (pos < 4'd12) run_sum = run_sum + 10'(dig * CHK_WEIGHT[pos]);
            case (pos)
                4'd0:    run_sex    = dig;
                4'd1:    run_year   = 7'(dig) * 7'd10;
                4'd2:    run_year   = run_year + 7'(dig);
                4'd3:    run_month  = 7'(dig) * 7'd10;
                4'd4:    run_month  = run_month + 7'(dig);
                4'd5:    run_day    = 7'(dig) * 7'd10;
                4'd6:    run_day    = run_day + 7'(dig);
                4'd7:    run_county = 7'(dig) * 7'd10;
                4'd8:    run_county = run_county + 7'(dig);
                4'd12:   run_check  = dig;
                default: ;
            endcase
        end
        if (run_count < 4'd14) run_count = run_count + 4'd1;
        if (last) begin
            v.kind = judge_code();
            v.ok   = (v.kind == pcv_pkg::ERR_OK);
            verdict_q.push_back(v);
            run_count    = '0;
            run_nondigit = 1'b0;
            run_sum      = '0;
            run_sex      = '0;
            run_year     = '0;
            run_month    = '0;
            run_day      = '0;
            run_county   = '0;
            run_check    = '0;
        end
    endfunction

    // weighted sum of the first twelve digits, mod 11
    function automatic int code_remainder(input t_chars c);
        int sum;
        sum = 0;
        for (int i = 0; i < 12; i++) sum += (c[i] - CH_ZERO) * CHK_WEIGHT[i];
        return sum % 11;
    endfunction

    // digit string from field values, with its check digit
    function automatic t_chars make_code(input int sex, yy, mon, day, county, serial);
        t_chars c;
        int     r;
        c.push_back(CH_ZERO + 8'(sex));
        c.push_back(CH_ZERO + 8'(yy / 10));
        c.push_back(CH_ZERO + 8'(yy % 10));
        c.push_back(CH_ZERO + 8'(mon / 10));
        c.push_back(CH_ZERO + 8'(mon % 10));
        c.push_back(CH_ZERO + 8'(day / 10));
        c.push_back(CH_ZERO + 8'(day % 10));
        c.push_back(CH_ZERO + 8'(county / 10));
        c.push_back(CH_ZERO + 8'(county % 10));
        c.push_back(CH_ZERO + 8'(serial / 100));
        c.push_back(CH_ZERO + 8'((serial / 10) % 10));
        c.push_back(CH_ZERO + 8'(serial % 10));
        r = code_remainder(c);
        c.push_back(CH_ZERO + 8'((r == 10) ? 1 : r));
        return c;
    endfunction

    // mostly well-formed codes, some broken on purpose, some noise
    function automatic t_chars random_code();
        t_chars     c;
        int         sex, yy, mon, day, county, kind, pos, dim;
        logic [7:0] b;
        sex    = $urandom_range(1, 9);
        yy     = $urandom_range(0, 99);
        mon    = $urandom_range(1, 12);
        dim    = month_length(mon, century_of(sex) + yy);
        day    = $urandom_range(1, dim);
        county = $urandom_range(1, 52);
        kind   = $urandom_range(0, 99);
        // noise strings of 1 to 20 characters, about half digits
        if (kind >= 90) begin
            repeat ($urandom_range(1, 20)) begin
                if ($urandom_range(0, 1)) c.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                else c.push_back(8'($urandom));
            end
            return c;
        end
        // broken fields
        if (kind >= 60 && kind < 64) sex = 0;
        else if (kind >= 64 && kind < 68) mon = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        else if (kind >= 68 && kind < 72) day = $urandom_range(0, 1) ? 0 : $urandom_range(dim + 1, 99);
        else if (kind >= 72 && kind < 76) county = $urandom_range(0, 1) ? 0 : $urandom_range(53, 99);
        c = make_code(sex, yy, mon, day, county, $urandom_range(0, 999));
        // broken characters
        if (kind >= 76 && kind < 80) begin
            c[12] = CH_ZERO + 8'((c[12] - CH_ZERO + $urandom_range(1, 9)) % 10);
        end else if (kind >= 80 && kind < 83) begin
            pos = $urandom_range(0, 12);
            do b = 8'($urandom); while (b >= CH_ZERO && b <= CH_NINE);
            c[pos] = b;
        end else if (kind >= 83 && kind < 86) begin
            c.delete($urandom_range(0, 12));
        end else if (kind >= 86 && kind < 88) begin
            repeat ($urandom_range(1, 8)) c.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (kind >= 88) begin
            pos = $urandom_range(0, 12);
            c[pos] = CH_ZERO + 8'($urandom_range(0, 9));
        end
        return c;
    endfunction

    // one character beat, then maybe a gap at the end of a burst
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        i_valid     <= 1'b1;
        i_character <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_ready);
        absorb_char(ch, last);
        sent_chars++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_code(input t_chars c);
        foreach (c[i]) send_char(c[i], i == c.size() - 1);
    endtask

    // hold off the sender until every pending verdict is back
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    task automatic test_valid_codes();
        t_chars c;
        gap_max = 4;
        send_code(make_code(1, 85, 6, 15, 40, 123));
        send_code(make_code(9, 99, 12, 31, 52, 999));
        send_code(make_code(1, 0, 1, 1, 1, 0));
        // leap day in 2000 by the 400 rule and in 1804 by the 4 rule
        send_code(make_code(5, 0, 2, 29, 12, 7));
        send_code(make_code(3, 4, 2, 29, 12, 7));
        // remainder of ten maps the check digit to one
        for (int s = 0; s < 1000; s++) begin
            c = make_code(2, 77, 3, 9, 21, s);
            if (code_remainder(c) == 10) break;
        end
        send_code(c);
    endtask

    task automatic test_field_errors();
        send_code(make_code(0, 80, 1, 1, 1, 1));
        send_code(make_code(2, 80, 0, 10, 10, 5));
        send_code(make_code(2, 80, 13, 10, 10, 5));
        send_code(make_code(9, 99, 99, 99, 99, 999));
        send_code(make_code(3, 50, 5, 0, 12, 7));
        send_code(make_code(4, 50, 4, 31, 12, 7));
        // 1900 is not a leap year, nor is 1999
        send_code(make_code(1, 0, 2, 29, 12, 7));
        send_code(make_code(1, 99, 2, 29, 12, 7));
        send_code(make_code(6, 10, 1, 32, 12, 7));
        send_code(make_code(7, 10, 1, 5, 0, 7));
        send_code(make_code(8, 10, 1, 5, 53, 7));
    endtask

    task automatic test_checksum();
        t_chars c;
        c = make_code(4, 60, 7, 20, 33, 456);
        c[12] = CH_ZERO + 8'((c[12] - CH_ZERO + 5) % 10);
        send_code(c);
    endtask

    task automatic test_length();
        t_chars c;
        c.push_back(8'hFF);
        send_code(c);
        c[0] = 8'h00;
        send_code(c);
        c = make_code(6, 21, 11, 30, 40, 321);
        c.pop_back();
        send_code(c);
        c = make_code(6, 21, 11, 30, 40, 321);
        c.push_back(CH_ZERO);
        send_code(c);
        // count saturates well past the limit
        repeat (6) c.push_back(CH_NINE);
        send_code(c);
    endtask

    task automatic test_nondigit();
        t_chars c;
        c = make_code(2, 66, 8, 8, 18, 88);
        c[5] = 8'h2F;
        send_code(c);
        c = make_code(2, 66, 8, 8, 18, 88);
        c[12] = 8'h3A;
        send_code(c);
        c = make_code(2, 66, 8, 8, 18, 88);
        c[0] = 8'h80;
        send_code(c);
    endtask

    // single-character strings back to back, one verdict per beat, then random codes and a drain
    task automatic test_backpressure();
        t_chars c;
        gap_max = 0;
        repeat (60) begin
            c.delete();
            c.push_back(8'($urandom));
            send_code(c);
        end
        repeat (8) send_code(random_code());
        wait_drain();
        gap_max = 4;
    endtask

    task automatic test_random(input int n_chars);
        int start;
        bit paused;
        start  = sent_chars;
        paused = 1'b0;
        while (sent_chars - start < n_chars) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 8;
                endcase
            end
            if (!paused && sent_chars - start >= n_chars / 2) begin
                wait_drain();
                paused = 1'b1;
            end
            send_code(random_code());
        end
    endtask

    // receiver: segments of always ready, random, periodic and mostly stalled
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 2'd1;
        case (rx_style)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            2:       i_ready <= (rx_phase != 2'd3);
            default: i_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // compare each result beat with the oldest pending verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result with nothing pending: code_valid %0b error_kind %0d",
                       o_code_valid, o_error_kind);
                fail_count++;
            end else begin
                want_v = verdict_q.pop_front();
                if (o_code_valid !== want_v.ok) begin
                    $error("code_valid: expected %0b, got %0b", want_v.ok, o_code_valid);
                    fail_count++;
                end
                if (o_error_kind !== want_v.kind) begin
                    $error("error_kind: expected %0d, got %0d", want_v.kind, o_error_kind);
                    fail_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_character <= 8'h00;
        i_last_char <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_valid_codes();
        test_field_errors();
        test_checksum();
        test_length();
        test_nondigit();
        test_backpressure();
        test_random(1500);
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_personal_code_validator: PASS");
        end else begin
            $display("tb_personal_code_validator: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("tb_personal_code_validator: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pcv_pkg.sv
rtl/pcv_accum.sv
rtl/pcv_judge.sv
rtl/personal_code_validator.sv
rtl/pcv_checker.sv
bench/tb_personal_code_validator.sv
